@@ sv/dit_pkg.sv @@
// Shared types for the disjoint interval tracker.
// No dependencies; the cell, chain, merge unit and top level import this package.
package dit_pkg;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PASS
  } state_t;

  // Per-cycle control of the cell chain
  typedef struct packed {
    logic shift;  // every cell takes its right neighbour, head leaves
    logic wr;     // write the emitted interval at the tail
  } chain_ctrl_t;

  // Per-cycle operation of the merge unit
  typedef struct packed {
    logic load;   // start of a transaction: hold <= [v, v]
    logic rd;     // stream the head interval through the merge
    logic fin;    // final step: flush the held interval
  } merge_op_t;

endpackage

@@ sv/dit_in_if.sv @@
// Input channel: one value per transaction, valid/ready handshake.
// No dependencies.
interface dit_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ sv/dit_out_if.sv @@
// Output channel: one stored interval per transaction, valid/ready handshake.
// No dependencies.
interface dit_out_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] interval_start;
  logic [VALUE_BITS-1:0] interval_end;
  logic                  last_interval;
  logic                  table_overflow;

  modport source (output valid, output interval_start, output interval_end,
                  output last_interval, output table_overflow, input ready);
  modport sink (input valid, input interval_start, input interval_end,
                input last_interval, input table_overflow, output ready);
endinterface

@@ sv/dit_cell.sv @@
// One table cell: holds one interval and tests it against the new value.
// Depends on dit_pkg.
module dit_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  sel,
  input  logic [VALUE_BITS-1:0] right_lo,
  input  logic [VALUE_BITS-1:0] right_hi,
  input  logic [VALUE_BITS-1:0] wr_lo,
  input  logic [VALUE_BITS-1:0] wr_hi,
  input  logic [VALUE_BITS-1:0] v,
  output logic [VALUE_BITS-1:0] lo,
  output logic [VALUE_BITS-1:0] hi,
  output logic                  touch
);
  import dit_pkg::*;

  localparam int VW1 = VALUE_BITS + 1;

  logic [VW1-1:0] hi_inc;
  logic [VW1-1:0] v_inc;

  // Adjacency test one bit wider so the ends do not wrap
  assign hi_inc = {1'b0, hi} + VW1'(1);
  assign v_inc  = {1'b0, v} + VW1'(1);
  assign touch  = (hi_inc >= {1'b0, v}) && ({1'b0, lo} <= v_inc);

  // Tail write wins over the shift from the right
  always_ff @(posedge clk) begin
    if (sel) begin
      lo <= wr_lo;
      hi <= wr_hi;
    end else if (shift) begin
      lo <= right_lo;
      hi <= right_hi;
    end
  end
endmodule

@@ sv/dit_chain.sv @@
// Row of interval cells kept as a compacted queue: head at cell 0,
// occupancy in count, tail writes at the first free cell.
// Depends on dit_pkg and dit_cell.
module dit_chain #(
  parameter int MAX_INTERVALS = 32,
  parameter int VALUE_BITS    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dit_pkg::chain_ctrl_t                   ctrl,
  input  logic [VALUE_BITS-1:0]                  wr_lo,
  input  logic [VALUE_BITS-1:0]                  wr_hi,
  input  logic [VALUE_BITS-1:0]                  v,
  output logic [VALUE_BITS-1:0]                  head_lo,
  output logic [VALUE_BITS-1:0]                  head_hi,
  output logic [$clog2(MAX_INTERVALS+1)-1:0]     count,
  output logic                                   any_touch
);
  import dit_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  logic [VALUE_BITS-1:0]    lo [MAX_INTERVALS+1];
  logic [VALUE_BITS-1:0]    hi [MAX_INTERVALS+1];
  logic [MAX_INTERVALS-1:0] touch;
  logic [MAX_INTERVALS-1:0] touch_live;
  logic [CW-1:0]            wr_idx;
  logic [CW-1:0]            count_next;

  // Beyond the last cell nothing is stored; feed the write bus
  assign lo[MAX_INTERVALS] = wr_lo;
  assign hi[MAX_INTERVALS] = wr_hi;

  // After a shift the first free cell is one further left
  assign wr_idx = ctrl.shift ? count - CW'(1) : count;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    dit_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk      (clk),
      .shift    (ctrl.shift),
      .sel      (ctrl.wr && (wr_idx == CW'(i))),
      .right_lo (lo[i+1]),
      .right_hi (hi[i+1]),
      .wr_lo    (wr_lo),
      .wr_hi    (wr_hi),
      .v        (v),
      .lo       (lo[i]),
      .hi       (hi[i]),
      .touch    (touch[i])
    );
    assign touch_live[i] = touch[i] && (CW'(i) < count);
  end

  assign head_lo   = lo[0];
  assign head_hi   = hi[0];
  assign any_touch = |touch_live;

  // Occupancy
  always_comb begin
    count_next = count;
    if (ctrl.shift && !ctrl.wr) begin
      count_next = count - CW'(1);
    end else if (!ctrl.shift && ctrl.wr) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end
endmodule

@@ sv/dit_merge.sv @@
// Streaming merge unit: holds the interval being built around the new
// value and decides, per head interval, what leaves towards the output.
// Depends on dit_pkg.
module dit_merge #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dit_pkg::merge_op_t    op,
  input  logic                  bypass,
  input  logic [VALUE_BITS-1:0] v,
  input  logic [VALUE_BITS-1:0] head_lo,
  input  logic [VALUE_BITS-1:0] head_hi,
  output logic                  emit,
  output logic [VALUE_BITS-1:0] emit_lo,
  output logic [VALUE_BITS-1:0] emit_hi
);
  import dit_pkg::*;

  localparam int VW1 = VALUE_BITS + 1;

  logic                  hold_valid;
  logic [VALUE_BITS-1:0] hold_lo;
  logic [VALUE_BITS-1:0] hold_hi;
  logic                  touch;
  logic                  below;

  // Head touches or overlaps the held interval
  assign touch = (({1'b0, head_hi} + VW1'(1)) >= {1'b0, hold_lo}) &&
                 ({1'b0, head_lo} <= ({1'b0, hold_hi} + VW1'(1)));
  // Head lies wholly below the held interval, with a gap of at least one
  assign below = ({1'b0, head_hi} + VW1'(1)) < {1'b0, hold_lo};

  // What leaves this cycle
  always_comb begin
    emit    = 1'b0;
    emit_lo = head_lo;
    emit_hi = head_hi;
    if (op.rd) begin
      if (!hold_valid || below) begin
        emit = 1'b1;
      end else if (!touch) begin
        emit    = 1'b1;
        emit_lo = hold_lo;
        emit_hi = hold_hi;
      end
    end else if (op.fin) begin
      emit    = hold_valid;
      emit_lo = hold_lo;
      emit_hi = hold_hi;
    end
  end

  // Held interval: grows on a touch, is swapped for a higher head
  always_ff @(posedge clk) begin
    if (op.load) begin
      hold_lo <= v;
      hold_hi <= v;
    end else if (op.rd && hold_valid && !below) begin
      if (touch) begin
        hold_lo <= (head_lo < hold_lo) ? head_lo : hold_lo;
        hold_hi <= (head_hi > hold_hi) ? head_hi : hold_hi;
      end else begin
        hold_lo <= head_lo;
        hold_hi <= head_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (op.load) begin
      hold_valid <= !bypass;
    end
  end
endmodule

@@ sv/disjoint_interval_tracker.sv @@
// Disjoint interval tracker, top level.
// Depends on dit_pkg, dit_in_if, dit_out_if, dit_chain, dit_merge.
//
// Usage: each transaction on item adds one value to a sorted table of
// disjoint, non-adjacent closed intervals. Intervals touching the value
// (containing it, or ending at value-1 / starting at value+1) merge with it;
// otherwise it becomes a new single-value interval. After every add the
// whole table is sent on listing, ascending, one interval per transaction,
// last_interval set on the final one. If the table is full and the value
// touches nothing, the value is dropped and every transaction of that
// listing carries table_overflow.
// Timing: item.ready is high only between adds. An add is accepted, then
// the value is tested against all cells, then the table rotates once
// through the merge unit, one cell per cycle while the output is not
// stalled, and a final step flushes the held interval (skipped when the
// value is dropped). The first interval is presented later when the lowest
// intervals merge into the value. listing has an output register; when the
// receiver stalls the rotation stalls with it. Reset empties the table and
// the output.
module disjoint_interval_tracker #(
  parameter int MAX_INTERVALS = 32,
  parameter int VALUE_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  dit_in_if.sink    item,
  dit_out_if.source listing
);
  import dit_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] v;
  logic [CW-1:0]         rem;
  logic [CW-1:0]         rem_next;
  logic                  drop;
  logic                  drop_next;

  chain_ctrl_t           chain_ctrl;
  merge_op_t             op;
  logic [VALUE_BITS-1:0] head_lo;
  logic [VALUE_BITS-1:0] head_hi;
  logic [CW-1:0]         count;
  logic                  any_touch;
  logic                  emit;
  logic [VALUE_BITS-1:0] emit_lo;
  logic [VALUE_BITS-1:0] emit_hi;
  logic                  adv;
  logic                  step;
  logic                  last;

  dit_chain #(.MAX_INTERVALS(MAX_INTERVALS), .VALUE_BITS(VALUE_BITS)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (chain_ctrl),
    .wr_lo     (emit_lo),
    .wr_hi     (emit_hi),
    .v         (v),
    .head_lo   (head_lo),
    .head_hi   (head_hi),
    .count     (count),
    .any_touch (any_touch)
  );

  dit_merge #(.VALUE_BITS(VALUE_BITS)) u_merge (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .bypass  (drop_next),
    .v       (v),
    .head_lo (head_lo),
    .head_hi (head_hi),
    .emit    (emit),
    .emit_lo (emit_lo),
    .emit_hi (emit_hi)
  );

  assign item.ready = (state == ST_IDLE);
  // Output slot free or being emptied
  assign adv  = !listing.valid || listing.ready;
  assign step = (state == ST_PASS) && adv;

  // Sequencer
  always_comb begin
    state_next = state;
    rem_next   = rem;
    drop_next  = drop;
    op         = '0;
    chain_ctrl = '0;
    last       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        drop_next  = (count == CW'(MAX_INTERVALS)) && !any_touch;
        rem_next   = count;
        op.load    = 1'b1;
        state_next = ST_PASS;
      end
      ST_PASS: begin
        if (step) begin
          if (rem != '0) begin
            op.rd    = 1'b1;
            rem_next = rem - CW'(1);
            if (drop && (rem == CW'(1))) begin
              last       = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            op.fin     = 1'b1;
            last       = 1'b1;
            state_next = ST_IDLE;
          end
        end
        chain_ctrl.shift = op.rd;
        chain_ctrl.wr    = emit;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rem   <= '0;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
      drop  <= drop_next;
    end
  end

  // Captured value
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      v <= item.value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      listing.valid <= 1'b0;
    end else if (adv) begin
      listing.valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      listing.interval_start <= emit_lo;
      listing.interval_end   <= emit_hi;
      listing.last_interval  <= last;
      listing.table_overflow <= drop;
    end
  end
endmodule

@@ sv/dit_checker.sv @@
// Port-level checks for the disjoint interval tracker, bound to the top.
// Depends on disjoint_interval_tracker.
module dit_checker #(
  parameter int VALUE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_ready,
  input logic                  listing_valid,
  input logic                  listing_ready,
  input logic [VALUE_BITS-1:0] interval_start,
  input logic [VALUE_BITS-1:0] interval_end,
  input logic                  last_interval,
  input logic                  table_overflow
);

  // One add at a time: no second transaction right after the first
  a_one_add: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted twice in a row");

  // A listing still in flight keeps the input closed
  a_listing_closed: assert property (@(posedge clk) disable iff (rst)
    listing_valid && !last_interval |-> !item_ready)
    else $error("input open in the middle of a listing");

  // The overflow mark is the same throughout one listing
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    listing_valid && listing_ready && !last_interval |=>
      !listing_valid || (table_overflow == $past(table_overflow)))
    else $error("overflow mark changed within a listing");

  // Stalled output holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    listing_valid && !listing_ready |=>
      listing_valid && $stable(interval_start) && $stable(interval_end) &&
      $stable(last_interval) && $stable(table_overflow))
    else $error("stalled listing transaction changed");

endmodule

bind disjoint_interval_tracker dit_checker #(.VALUE_BITS(VALUE_BITS)) u_dit_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .listing_valid  (listing.valid),
  .listing_ready  (listing.ready),
  .interval_start (listing.interval_start),
  .interval_end   (listing.interval_end),
  .last_interval  (listing.last_interval),
  .table_overflow (listing.table_overflow)
);

@@ bench/disjoint_interval_tracker_tb.sv @@
// Self-checking bench for disjoint_interval_tracker: directed adds, then random adds.
// Depends on the RTL package, the dit_in_if/dit_out_if interfaces and the top level.
module disjoint_interval_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 32;
  localparam int VBITS       = 16;
  localparam int RANDOM_ADDS = 189;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;
  localparam int HOLD_AFTER  = 150;  // results before the long receiver hold-off
  localparam int HOLD_LEN    = 600;

  typedef logic [VBITS-1:0] val_t;

  // One interval as it should appear on the listing channel
  typedef struct packed {
    val_t lo;
    val_t hi;
    logic last;
    logic ovf;
  } span_t;

  // Directed row: spans = 0 means the listing comes from the predictor,
  // otherwise the listing is typed in (one or two intervals).
  typedef struct packed {
    val_t       value;
    logic [1:0] spans;
    val_t       lo0;
    val_t       hi0;
    val_t       lo1;
    val_t       hi1;
  } step_row_t;

  localparam int NUM_STEPS = 21;

  step_row_t steps [NUM_STEPS] = '{
    '{16'd0,     2'd1, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd65535, 2'd2, 16'd0,     16'd0,     16'd65535, 16'd65535},
    '{16'd1,     2'd2, 16'd0,     16'd1,     16'd65535, 16'd65535},
    '{16'd65534, 2'd2, 16'd0,     16'd1,     16'd65534, 16'd65535},
    '{16'd0,     2'd2, 16'd0,     16'd1,     16'd65534, 16'd65535},
    '{16'd65535, 2'd2, 16'd0,     16'd1,     16'd65534, 16'd65535},
    '{16'd3,     2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd5,     2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd4,     2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd2,     2'd2, 16'd0,     16'd5,     16'd65534, 16'd65535},
    '{16'd32768, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd32767, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd21845, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd43690, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd21846, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd43688, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd43689, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd7,     2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd65532, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd65533, 2'd0, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd6,     2'd0, 16'd0,     16'd0,     16'd0,     16'd0}
  };

  logic clk;
  logic rst;

  dit_in_if  #(.VALUE_BITS(VBITS)) item_ch ();
  dit_out_if #(.VALUE_BITS(VBITS)) listing_ch ();

  disjoint_interval_tracker #(
    .MAX_INTERVALS(NUM_SLOTS),
    .VALUE_BITS   (VBITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .listing(listing_ch)
  );

  // Predictor state: sorted interval table
  val_t  span_lo [NUM_SLOTS];
  val_t  span_hi [NUM_SLOTS];
  int    span_count;
  span_t listing_due [$];

  int fail_count;
  int results_seen;
  int adds_done;
  int drops_seen;
  int bridges_seen;
  int peak_count;
  int src_idle_pct;
  int sink_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d intervals still due", cycles, listing_due.size());
    $display("simulation failed");
    $finish;
  end

  // Merge v into the table; returns 1 when the value is dropped on a full table
  function automatic bit absorb_value(val_t v);
    int             first;
    int             past;
    int             gone;
    int             k;
    logic [VBITS:0] v_wide;
    val_t           lo;
    val_t           hi;
    v_wide = {1'b0, v};
    lo     = v;
    hi     = v;
    first  = 0;
    // first interval whose end is not below v-1 (one bit wider, no wrap)
    while (first < span_count && ({1'b0, span_hi[first]} + 1'b1) < v_wide)
      first++;
    // every following interval starting at or below v+1 touches v
    past = first;
    while (past < span_count && {1'b0, span_lo[past]} <= v_wide + 1'b1) begin
      if (span_lo[past] < lo) lo = span_lo[past];
      if (span_hi[past] > hi) hi = span_hi[past];
      past++;
    end
    if (past == first) begin
      if (span_count >= NUM_SLOTS) begin
        drops_seen++;
        return 1'b1;
      end
      for (k = span_count; k > first; k--) begin
        span_lo[k] = span_lo[k-1];
        span_hi[k] = span_hi[k-1];
      end
      span_lo[first] = v;
      span_hi[first] = v;
      span_count++;
      if (span_count > peak_count) peak_count = span_count;
      return 1'b0;
    end
    // merged: close up the intervals swallowed by the first one
    span_lo[first] = lo;
    span_hi[first] = hi;
    gone = past - first - 1;
    if (gone > 0) bridges_seen++;
    for (k = first + 1; k + gone < span_count; k++) begin
      span_lo[k] = span_lo[k+gone];
      span_hi[k] = span_hi[k+gone];
    end
    span_count -= gone;
    return 1'b0;
  endfunction

  // Add v and queue the listing it should produce
  task automatic predict_listing(val_t v);
    bit    dropped;
    span_t s;
    dropped = absorb_value(v);
    for (int k = 0; k < span_count; k++) begin
      s.lo   = span_lo[k];
      s.hi   = span_hi[k];
      s.last = (k == span_count - 1);
      s.ovf  = dropped;
      listing_due.insert(listing_due.size(), s);
    end
  endtask

  // Present one value and wait for the accepting edge; returns at that edge
  task automatic offer_value(val_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    adds_done++;
  endtask

  // Sender stops until every queued interval has come out
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (listing_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a value that reaches the interesting parts of the table
  function automatic val_t pick_value();
    int idx;
    int base;
    int sel;
    sel = $urandom_range(99);
    if (span_count == 0 || sel < 40) return val_t'($urandom_range(65535));
    if (sel < 48) begin
      case ($urandom_range(3))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'd65534;
        default: return 16'd65535;
      endcase
    end
    // near an edge: inside, touching, or leaving a one-wide gap for a later bridge
    idx  = $urandom_range(span_count - 1);
    base = $urandom_range(1) ? int'(span_lo[idx]) : int'(span_hi[idx]);
    return val_t'(base + $urandom_range(4) - 2);
  endfunction

  // Receiver: random ready, plus one long hold-off counted here
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    listing_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        listing_ch.ready <= 1'b0;
      end else begin
        listing_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Listing checker: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    span_t want;
    if (!rst && listing_ch.valid && listing_ch.ready) begin
      results_seen++;
      if (listing_due.size() == 0) begin
        $error("listing transaction with nothing expected: [%0d,%0d]",
               listing_ch.interval_start, listing_ch.interval_end);
        fail_count++;
      end else begin
        want = listing_due.pop_front();
        if (listing_ch.interval_start !== want.lo) begin
          $error("interval_start: expected %0d, got %0d", want.lo, listing_ch.interval_start);
          fail_count++;
        end
        if (listing_ch.interval_end !== want.hi) begin
          $error("interval_end: expected %0d, got %0d", want.hi, listing_ch.interval_end);
          fail_count++;
        end
        if (listing_ch.last_interval !== want.last) begin
          $error("last_interval: expected %0d, got %0d", want.last, listing_ch.last_interval);
          fail_count++;
        end
        if (listing_ch.table_overflow !== want.ovf) begin
          $error("table_overflow: expected %0d, got %0d", want.ovf, listing_ch.table_overflow);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    span_t s;
    fail_count    = 0;
    results_seen  = 0;
    adds_done     = 0;
    drops_seen    = 0;
    bridges_seen  = 0;
    peak_count    = 0;
    span_count    = 0;
    src_idle_pct  = 32;
    sink_idle_pct = 76;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    rst           = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed adds: extremes, containment, bridges
    for (int r = 0; r < NUM_STEPS; r++) begin
      offer_value(steps[r].value);
      if (steps[r].spans == 2'd0) begin
        predict_listing(steps[r].value);
      end else begin
        void'(absorb_value(steps[r].value));
        s.lo   = steps[r].lo0;
        s.hi   = steps[r].hi0;
        s.last = (steps[r].spans == 2'd1);
        s.ovf  = 1'b0;
        listing_due.insert(listing_due.size(), s);
        if (steps[r].spans == 2'd2) begin
          s.lo   = steps[r].lo1;
          s.hi   = steps[r].hi1;
          s.last = 1'b1;
          listing_due.insert(listing_due.size(), s);
        end
      end
      @(negedge clk);
    end
    settle();

    // Random adds in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 32;
          sink_idle_pct = 76;
        end
        1: begin
          src_idle_pct  = 76;
          sink_idle_pct = 32;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_ADDS / 3; i++) begin
        val_t v;
        v = pick_value();
        offer_value(v);
        predict_listing(v);
        @(negedge clk);
      end
      settle();
    end

    if (listing_due.size() != 0) begin
      $error("%0d expected intervals never listed", listing_due.size());
      fail_count++;
    end
    $display("%0d adds, %0d interval transactions checked; table peaked at %0d entries",
             adds_done, results_seen, peak_count);
    $display("%0d adds dropped on a full table, %0d merges joined neighbours",
             drops_seen, bridges_seen);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
